// ===== rtl/dmlr_pkg.sv =====
// ----------------------------------------------------------------------------
// dmlr_pkg: shared types and constants of the downmix resampler
// Holds the sequencer states, unit status word, register codes and the
// fixed field widths used by every file of the block.
// ----------------------------------------------------------------------------
package dmlr_pkg;

	// Fixed widths of the ports.
	localparam int SAMPLE_W       = 16;
	localparam int NUM_CHAN_PORTS = 8;
	localparam int COUNT_W        = 4;
	localparam int STEP_W         = 21;
	localparam int CFG_DATA_W     = 32;
	localparam int CFG_ADDR_W     = 3;

	// Result count per input word.
	localparam logic [2:0] MAX_RESULTS = 3'd4;
	localparam logic [2:0] LAST_COUNT  = 3'd3;

	// Register index codes, taken from paddr[2].
	localparam logic CFG_CHANNEL_COUNT = 1'b0;
	localparam logic CFG_PHASE_STEP    = 1'b1;

	// Reset values of the registers.
	localparam logic [COUNT_W-1:0] CHANNEL_COUNT_RST = 4'd2;
	localparam logic [STEP_W-1:0]  PHASE_STEP_RST    = 21'd196608;

	// Status of a multi-cycle unit.
	typedef struct packed {
		logic busy;
		logic done;
	} unit_status_t;

	// Main sequencer states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_MONO,
		S_CHECK,
		S_INTERP,
		S_EMIT
	} seq_state_t;

endpackage

// ===== rtl/dmlr_mono.sv =====
// ----------------------------------------------------------------------------
// dmlr_mono: channel downmix with a bit-serial divider
// Shifts the channel samples through an accumulator one channel per cycle,
// then divides the sum by the channel count one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dmlr_mono #(
	parameter int MAX_CH = 8
) (
	input  logic                                                 clk,
	input  logic                                                 arst_n,
	input  logic                                                 start,
	input  logic                                                 silent,
	input  logic [dmlr_pkg::NUM_CHAN_PORTS-1:0][dmlr_pkg::SAMPLE_W-1:0] chans,
	input  logic [dmlr_pkg::COUNT_W-1:0]                         nch,
	output dmlr_pkg::unit_status_t                               status,
	output logic signed [dmlr_pkg::SAMPLE_W-1:0]                 mono
);
	import dmlr_pkg::*;

	localparam int SUM_W = SAMPLE_W + $clog2(MAX_CH);
	localparam int LAST  = MAX_CH + SUM_W;
	localparam int SW    = $clog2(LAST + 1);

	logic                       busy_q;
	logic                       done_q;
	logic [SW-1:0]              step_q;
	logic signed [SAMPLE_W-1:0] chan_q [MAX_CH];
	logic                       silent_q;
	logic signed [SUM_W-1:0]    acc_q;
	logic [SUM_W-1:0]           quot_q;
	logic [2:0]                 rem_q;
	logic                       neg_q;
	logic [COUNT_W-1:0]         nch_eff;
	logic [3:0]                 trial;
	logic                       qbit;

	// Channel count limited to the range the datapath supports.
	always_comb begin
		if (nch == '0) begin
			nch_eff = 4'd1;
		end else if (nch > COUNT_W'(MAX_CH)) begin
			nch_eff = COUNT_W'(MAX_CH);
		end else begin
			nch_eff = nch;
		end
	end

	// One restoring division step.
	assign trial = {rem_q, quot_q[SUM_W-1]};
	assign qbit  = (trial >= nch_eff);

	// Step counter and status.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == SW'(LAST)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Accumulate, take the magnitude, then divide.
	always_ff @(posedge clk) begin
		if (start) begin
			for (int i = 0; i < MAX_CH; i++) begin
				chan_q[i] <= chans[i];
			end
			silent_q <= silent;
			acc_q    <= '0;
		end else if (busy_q) begin
			if (step_q < SW'(MAX_CH)) begin
				if (!silent_q && step_q < SW'(nch_eff)) begin
					acc_q <= acc_q + SUM_W'(chan_q[0]);
				end
				for (int i = 0; i < MAX_CH - 1; i++) begin
					chan_q[i] <= chan_q[i+1];
				end
			end else if (step_q == SW'(MAX_CH)) begin
				neg_q  <= acc_q[SUM_W-1];
				quot_q <= acc_q[SUM_W-1] ? SUM_W'(-acc_q) : SUM_W'(acc_q);
				rem_q  <= '0;
			end else begin
				rem_q  <= qbit ? 3'(trial - nch_eff) : trial[2:0];
				quot_q <= {quot_q[SUM_W-2:0], qbit};
			end
		end
	end

	// The quotient truncates toward zero; the sign is put back here.
	assign mono   = neg_q ? SAMPLE_W'(-quot_q) : SAMPLE_W'(quot_q);
	assign status = '{busy: busy_q, done: done_q};

endmodule

// ===== rtl/dmlr_interp.sv =====
// ----------------------------------------------------------------------------
// dmlr_interp: linear interpolation and output scaling
// Forms prev + (cur - prev) * phase with a bit-serial shift-add multiplier,
// then scales by 32767/32768, rounds half away from zero and saturates.
// ----------------------------------------------------------------------------
module dmlr_interp #(
	parameter int F = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic signed [dmlr_pkg::SAMPLE_W-1:0] prev,
	input  logic signed [dmlr_pkg::SAMPLE_W-1:0] cur,
	input  logic [F-1:0]                         phase,
	output dmlr_pkg::unit_status_t               status,
	output logic signed [dmlr_pkg::SAMPLE_W-1:0] sample
);
	import dmlr_pkg::*;

	localparam int AW   = F + 17;
	localparam int XW   = F + 18;
	localparam int TW   = XW + 15;
	localparam int LAST = F + 3;
	localparam int SW   = $clog2(LAST + 1);
	localparam logic [TW:0] HALF = (TW + 1)'(1) << (14 + F);

	logic                       busy_q;
	logic                       done_q;
	logic [SW-1:0]              step_q;
	logic [F-1:0]               phase_sr_q;
	logic signed [SAMPLE_W:0]   diff_q;
	logic signed [SAMPLE_W-1:0] prev_q;
	logic signed [AW-1:0]       acc_q;
	logic signed [XW-1:0]       x_q;
	logic [XW-1:0]              mag_q;
	logic                       neg_q;
	logic [TW-1:0]              t_q;
	logic signed [SAMPLE_W-1:0] sample_q;
	logic [TW:0]                rnd;
	logic [18:0]                q;
	logic [18:0]                qc;

	// Rounding and saturation of the scaled magnitude.
	always_comb begin
		rnd = {1'b0, t_q} + HALF;
		q   = rnd[TW:15+F];
		if (neg_q) begin
			qc = (q > 19'd32768) ? 19'd32768 : q;
		end else begin
			qc = (q > 19'd32767) ? 19'd32767 : q;
		end
	end

	// Step counter and status.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == SW'(LAST)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Multiply MSB first, then add the base, take magnitude, scale, round.
	always_ff @(posedge clk) begin
		if (start) begin
			phase_sr_q <= phase;
			diff_q     <= (SAMPLE_W + 1)'(cur) - (SAMPLE_W + 1)'(prev);
			prev_q     <= prev;
			acc_q      <= '0;
		end else if (busy_q) begin
			if (step_q < SW'(F)) begin
				acc_q      <= (acc_q <<< 1) + (phase_sr_q[F-1] ? AW'(diff_q) : AW'(0));
				phase_sr_q <= phase_sr_q << 1;
			end else if (step_q == SW'(F)) begin
				x_q <= (XW'(prev_q) <<< F) + XW'(acc_q);
			end else if (step_q == SW'(F + 1)) begin
				neg_q <= x_q[XW-1];
				mag_q <= x_q[XW-1] ? XW'(-x_q) : XW'(x_q);
			end else if (step_q == SW'(F + 2)) begin
				t_q <= (TW'(mag_q) << 15) - TW'(mag_q);
			end else begin
				sample_q <= neg_q ? SAMPLE_W'(-qc) : SAMPLE_W'(qc);
			end
		end
	end

	assign sample = sample_q;
	assign status = '{busy: busy_q, done: done_q};

endmodule

// ===== rtl/downmix_linear_resampler_unit.sv =====
// ----------------------------------------------------------------------------
// downmix_linear_resampler_unit: mono downmix and linear resampler
// Averages the active channels of each frame and emits interpolated mono
// samples at the rate set by the phase step register.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one frame word (chan0..chan7, silent) is taken when
//   in_valid is high and in_stall is low. in_stall stays high while a frame
//   is in work.
//   Output channel: each result word (out_sample, last_of_run) is held in an
//   output register until out_valid is high and out_stall is low. A frame
//   causes zero to four words; last_of_run marks the final one.
//   Timing: at eight channels the downmix shifts the channels through an
//   accumulator and then runs a 19-bit bit-serial divider; each result then
//   runs the bit-serial phase multiplier, plus any wait for the output
//   register, and a check state closes the frame. The next frame is taken
//   only after all of this.
//   A stalled receiver holds the last word; the sequencer then waits with
//   its next result until the output register is free.
//   Reset clears the phase and previous sample to zero and loads the
//   registers with channel_count = 2 and phase_step = 3.0.
//   Registers: channel_count at byte address 0, phase_step at 4; write only
//   while the block is idle.
// ----------------------------------------------------------------------------
module downmix_linear_resampler_unit #(
	parameter int MAX_CHANNELS    = 8,
	parameter int PHASE_FRAC_BITS = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [dmlr_pkg::CFG_ADDR_W-1:0]        paddr,
	input  logic [dmlr_pkg::CFG_DATA_W-1:0]        pwdata,
	output logic [dmlr_pkg::CFG_DATA_W-1:0]        prdata,
	output logic                                   pready,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic signed [dmlr_pkg::SAMPLE_W-1:0]   chan0,
	input  logic signed [dmlr_pkg::SAMPLE_W-1:0]   chan1,
	input  logic signed [dmlr_pkg::SAMPLE_W-1:0]   chan2,
	input  logic signed [dmlr_pkg::SAMPLE_W-1:0]   chan3,
	input  logic signed [dmlr_pkg::SAMPLE_W-1:0]   chan4,
	input  logic signed [dmlr_pkg::SAMPLE_W-1:0]   chan5,
	input  logic signed [dmlr_pkg::SAMPLE_W-1:0]   chan6,
	input  logic signed [dmlr_pkg::SAMPLE_W-1:0]   chan7,
	input  logic                                   silent,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [dmlr_pkg::SAMPLE_W-1:0]   out_sample,
	output logic                                   last_of_run
);
	import dmlr_pkg::*;

	localparam int F  = PHASE_FRAC_BITS;
	localparam int PW = ((F > STEP_W) ? F : STEP_W) + 1;
	localparam logic [PW-1:0] ONE      = PW'(1) << F;
	localparam logic [PW-1:0] MIN_STEP = PW'(1) << (F - 2);

	seq_state_t                 state_q, state_d;
	logic [COUNT_W-1:0]         channel_count_q;
	logic [STEP_W-1:0]          phase_step_q;
	logic [PW-1:0]              phase_q;
	logic signed [SAMPLE_W-1:0] prev_q;
	logic [2:0]                 count_q;
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] out_sample_q;
	logic                       last_q;
	logic                       cfg_write;
	logic                       accept;
	logic                       out_free;
	logic                       mono_start;
	logic                       interp_start;
	logic                       emit;
	logic                       finish;
	logic [PW-1:0]              step_eff;
	logic [PW-1:0]              next_phase;
	logic                       last_d;
	unit_status_t               mono_st;
	unit_status_t               interp_st;
	logic signed [SAMPLE_W-1:0] mono_sample;
	logic signed [SAMPLE_W-1:0] interp_sample;

	// Configuration port: writes complete in the access cycle.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_count_q <= CHANNEL_COUNT_RST;
			phase_step_q    <= PHASE_STEP_RST;
		end else if (cfg_write) begin
			case (paddr[2])
				CFG_CHANNEL_COUNT: channel_count_q <= pwdata[COUNT_W-1:0];
				CFG_PHASE_STEP:    phase_step_q    <= pwdata[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			CFG_CHANNEL_COUNT: prdata = CFG_DATA_W'(channel_count_q);
			CFG_PHASE_STEP:    prdata = CFG_DATA_W'(phase_step_q);
			default:           prdata = '0;
		endcase
	end

	// Handshakes.
	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// Step held to at least one quarter, next phase and end-of-run flag.
	assign step_eff   = (PW'(phase_step_q) < MIN_STEP) ? MIN_STEP : PW'(phase_step_q);
	assign next_phase = phase_q + step_eff;
	assign last_d     = (next_phase >= ONE) || (count_q == LAST_COUNT);

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer next state and controls.
	always_comb begin
		state_d      = state_q;
		mono_start   = 1'b0;
		interp_start = 1'b0;
		emit         = 1'b0;
		finish       = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					mono_start = 1'b1;
					state_d    = S_MONO;
				end
			end
			S_MONO: begin
				if (mono_st.done) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (phase_q < ONE && count_q < MAX_RESULTS) begin
					interp_start = 1'b1;
					state_d      = S_INTERP;
				end else begin
					finish  = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_INTERP: begin
				if (interp_st.done) begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (out_free) begin
					emit    = 1'b1;
					state_d = S_CHECK;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Phase, previous sample and result count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			prev_q  <= '0;
			count_q <= '0;
		end else if (emit) begin
			phase_q <= next_phase;
			count_q <= count_q + 1'b1;
		end else if (finish) begin
			phase_q <= phase_q - ONE;
			prev_q  <= mono_sample;
			count_q <= '0;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_sample_q <= interp_sample;
			last_q       <= last_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_sample  = out_sample_q;
	assign last_of_run = last_q;

	// Downmix unit.
	dmlr_mono #(
		.MAX_CH(MAX_CHANNELS)
	) u_mono (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mono_start),
		.silent (silent),
		.chans  ({chan7, chan6, chan5, chan4, chan3, chan2, chan1, chan0}),
		.nch    (channel_count_q),
		.status (mono_st),
		.mono   (mono_sample)
	);

	// Interpolation unit.
	dmlr_interp #(
		.F(F)
	) u_interp (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (interp_start),
		.prev   (prev_q),
		.cur    (mono_sample),
		.phase  (phase_q[F-1:0]),
		.status (interp_st),
		.sample (interp_sample)
	);

	// A taken frame word blocks the input on the next cycle.
	a_stall_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> in_stall)
		else $error("input not stalled after a frame word was taken");

	// No unit is at work while the sequencer waits for a frame.
	a_idle_units: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (!mono_st.busy && !interp_st.busy))
		else $error("unit busy while sequencer idle");

	// A result loaded from the sequencer is offered on the next cycle.
	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> out_valid)
		else $error("emitted result not offered");

	// A frame never causes more than four results.
	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MAX_RESULTS)
		else $error("result count above limit");

endmodule

// ===== tb/sv/downmix_linear_resampler_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// downmix_linear_resampler_unit_tb: self-checking bench of the mono resampler
// Frames are sent through a driver queue, and each accepted frame is run
// through a bit-exact model of the downmix and phase interpolation. Each word
// that leaves the block is compared with the oldest predicted word. Several
// register settings and handshake pressure modes are covered.
// ----------------------------------------------------------------------------
module downmix_linear_resampler_unit_tb;
	import dmlr_pkg::*;

	localparam int     CHANNELS      = 8;
	localparam int     FRAC_BITS     = 16;
	localparam longint PHASE_ONE     = longint'(1) << FRAC_BITS;
	localparam longint MIN_STEP      = PHASE_ONE >> 2;
	localparam int     SETTLE_CYCLES = 200;
	localparam int     REPORT_LIMIT  = 10;

	localparam logic [CFG_ADDR_W-1:0] ADDR_CHANNEL_COUNT = {CFG_CHANNEL_COUNT, 2'b00};
	localparam logic [CFG_ADDR_W-1:0] ADDR_PHASE_STEP    = {CFG_PHASE_STEP, 2'b00};

	// One input frame as it is presented on the bus.
	typedef struct packed {
		logic                                   silent;
		logic [NUM_CHAN_PORTS-1:0][SAMPLE_W-1:0] chan;
	} frame_t;

	// One output word.
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       last;
	} mono_word_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                  psel    = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite  = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr   = '0;
	logic [CFG_DATA_W-1:0] pwdata  = '0;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;

	logic                       in_valid = 1'b0;
	logic                       in_stall;
	logic signed [SAMPLE_W-1:0] chan0 = '0;
	logic signed [SAMPLE_W-1:0] chan1 = '0;
	logic signed [SAMPLE_W-1:0] chan2 = '0;
	logic signed [SAMPLE_W-1:0] chan3 = '0;
	logic signed [SAMPLE_W-1:0] chan4 = '0;
	logic signed [SAMPLE_W-1:0] chan5 = '0;
	logic signed [SAMPLE_W-1:0] chan6 = '0;
	logic signed [SAMPLE_W-1:0] chan7 = '0;
	logic                       silent = 1'b0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic signed [SAMPLE_W-1:0] out_sample;
	logic                       last_of_run;

	// Shadow registers and model state.
	logic [COUNT_W-1:0] cfg_count = CHANNEL_COUNT_RST;
	logic [STEP_W-1:0]  cfg_step  = PHASE_STEP_RST;
	longint             phase_acc = 0;
	int                 prev_mono = 0;

	frame_t     pending_frames[$];
	mono_word_t expected_words[$];
	frame_t     frame_on_bus = '0;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int frames_sent    = 0;
	int words_checked  = 0;
	int settings_run   = 0;
	int error_count    = 0;

	downmix_linear_resampler_unit #(
		.MAX_CHANNELS   (CHANNELS),
		.PHASE_FRAC_BITS(FRAC_BITS)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.chan0      (chan0),
		.chan1      (chan1),
		.chan2      (chan2),
		.chan3      (chan3),
		.chan4      (chan4),
		.chan5      (chan5),
		.chan6      (chan6),
		.chan7      (chan7),
		.silent     (silent),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_sample (out_sample),
		.last_of_run(last_of_run)
	);

	// Clock: 10 ns period.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Interpolated value scaled by 32767/32768, rounded half away from zero
	// and saturated to the sample range.
	function automatic logic signed [SAMPLE_W-1:0] interp_sample(int prev, int cur,
			longint phase);
		longint acc;
		longint prod;
		longint mag;
		longint q;
		acc  = longint'(prev) * PHASE_ONE + longint'(cur - prev) * phase;
		prod = acc * longint'(32767);
		mag  = (prod < 0) ? -prod : prod;
		q    = (mag + (longint'(1) << (14 + FRAC_BITS))) >>> (15 + FRAC_BITS);
		if (prod < 0) begin
			if (q > 32768) q = 32768;
			q = -q;
		end else if (q > 32767) begin
			q = 32767;
		end
		return SAMPLE_W'(q);
	endfunction

	// Downmix one frame and queue every word it should cause.
	function automatic void resample_frame(frame_t f);
		mono_word_t words[4];
		int         nch;
		int         sum;
		int         cur;
		int         n;
		int         c;
		int         s16;
		longint     step;
		nch  = int'(cfg_count);
		if (nch < 1) nch = 1;
		if (nch > CHANNELS) nch = CHANNELS;
		step = (longint'(cfg_step) < MIN_STEP) ? MIN_STEP : longint'(cfg_step);
		cur  = 0;
		if (!f.silent) begin
			sum = 0;
			for (c = 0; c < nch; c++) begin
				s16 = $signed(f.chan[c]);
				sum += s16;
			end
			cur = sum / nch;
		end
		n = 0;
		while (phase_acc < PHASE_ONE && n < int'(MAX_RESULTS)) begin
			words[n].sample = interp_sample(prev_mono, cur, phase_acc);
			words[n].last   = 1'b0;
			n++;
			phase_acc += step;
		end
		if (n > 0) words[n-1].last = 1'b1;
		for (c = 0; c < n; c++) expected_words.insert(expected_words.size(), words[c]);
		phase_acc -= PHASE_ONE;
		prev_mono = cur;
	endfunction

	// Frame driver: holds a stalled word, otherwise loads the next one or idles.
	always @(posedge clk) begin : frame_driver
		frame_t f;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				resample_frame(frame_on_bus);
				frames_sent++;
			end
			if (!in_valid || !in_stall) begin
				if (pending_frames.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					f = pending_frames.pop_front();
					frame_on_bus <= f;
					chan0        <= f.chan[0];
					chan1        <= f.chan[1];
					chan2        <= f.chan[2];
					chan3        <= f.chan[3];
					chan4        <= f.chan[4];
					chan5        <= f.chan[5];
					chan6        <= f.chan[6];
					chan7        <= f.chan[7];
					silent       <= f.silent;
					in_valid     <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Output monitor: compares each taken word with the oldest prediction.
	always @(posedge clk) begin : word_monitor
		mono_word_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_words.size() == 0) begin
					error_count++;
					if (error_count <= REPORT_LIMIT)
						$display("unexpected word %0d: sample %0d last %0b",
							words_checked, out_sample, last_of_run);
				end else begin
					want = expected_words.pop_front();
					if (out_sample !== want.sample || last_of_run !== want.last) begin
						error_count++;
						if (error_count <= REPORT_LIMIT)
							$display("word %0d: expected sample %0d last %0b, got sample %0d last %0b",
								words_checked, want.sample, want.last, out_sample, last_of_run);
					end
				end
				words_checked++;
			end
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// One register write: setup cycle, then access cycle.
	task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic set_config(logic [COUNT_W-1:0] count, logic [STEP_W-1:0] step);
		write_reg(ADDR_CHANNEL_COUNT, CFG_DATA_W'(count));
		write_reg(ADDR_PHASE_STEP, CFG_DATA_W'(step));
		cfg_count = count;
		cfg_step  = step;
		@(negedge clk);
	endtask

	// Wait until every frame is taken and every word is back, then let the
	// block finish a frame that causes no word.
	task automatic drain_block();
		do @(negedge clk);
		while (pending_frames.size() != 0 || in_valid || expected_words.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Field extremes, sign patterns and silent frames.
	task automatic push_directed();
		frame_t f;
		int     k;
		int     c;
		for (k = 0; k < 12; k++) begin
			for (c = 0; c < NUM_CHAN_PORTS; c++) begin
				case (k)
					0, 8:    f.chan[c] = 16'h7FFF;
					1, 9:    f.chan[c] = 16'h8000;
					2:       f.chan[c] = 16'h0000;
					3:       f.chan[c] = c[0] ? 16'h8000 : 16'h7FFF;
					4:       f.chan[c] = (c == 0) ? 16'h7FFF : 16'h8000;
					5:       f.chan[c] = 16'hFFFF;
					6:       f.chan[c] = 16'h0001;
					7:       f.chan[c] = c[0] ? 16'hAAAA : 16'h5555;
					10:      f.chan[c] = 16'h8000;
					default: f.chan[c] = 16'(c * 4099 - 16000);
				endcase
			end
			// Silent frames with full-scale channels must still give zero.
			f.silent = (k == 8 || k == 9);
			pending_frames.insert(pending_frames.size(), f);
		end
	endtask

	// One phase: program the registers, set the pressure, send and drain.
	task automatic run_phase(logic [COUNT_W-1:0] count, logic [STEP_W-1:0] step,
			int idle_pct, int stall_pct, int n_random, bit with_directed);
		frame_t f;
		int     i;
		int     c;
		int     style;
		set_config(count, step);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		if (with_directed) push_directed();
		for (i = 0; i < n_random; i++) begin
			for (c = 0; c < NUM_CHAN_PORTS; c++) begin
				style = $urandom_range(99);
				if (style < 70)
					f.chan[c] = 16'($urandom);
				else if (style < 85)
					f.chan[c] = $urandom_range(1) ? 16'h7FFF : 16'h8000;
				else
					f.chan[c] = 16'($urandom_range(64) - 32);
			end
			f.silent = ($urandom_range(99) < 10);
			pending_frames.insert(pending_frames.size(), f);
		end
		drain_block();
		settings_run++;
	endtask

	// Main sequence.
	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset values of the registers, step of three: most frames cause no word.
		push_directed();
		drain_block();
		settings_run++;

		run_phase(4'd8, 21'd16384, 0, 0, 40, 1'b1);
		run_phase(4'd0, 21'd0, 65, 0, 90, 1'b0);
		run_phase(4'd15, 21'd65536, 0, 65, 90, 1'b0);
		run_phase(4'd1, 21'd1048576, 32, 32, 90, 1'b0);
		run_phase(COUNT_W'($urandom_range(8, 1)), STEP_W'($urandom_range(200000, 16384)),
			32, 32, 90, 1'b0);

		if (expected_words.size() != 0) begin
			error_count += expected_words.size();
			$display("%0d predicted words never arrived", expected_words.size());
		end
		$display("Sent %0d frames over %0d register settings and four handshake modes.",
			frames_sent, settings_run);
		$display("Compared %0d output words, %0d errors.", words_checked, error_count);
		if (error_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// Watchdog.
	initial begin
		#10_000_000;
		$display("timeout with %0d frames pending and %0d words outstanding",
			pending_frames.size(), expected_words.size());
		$display("CHECK FAILED");
		$finish;
	end

endmodule
